// File: src/nir_pkg.sv
// Package with the shared types, codes and defaults of the input-queued router.
package nir_pkg;

  // Defaults for the top-level parameters.
  localparam int NUM_PORTS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int NUM_DESTS_DEF   = 16;

  // Saturation value of the packet counters.
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // Result kinds.
  localparam logic [2:0] KIND_ACCEPT    = 3'd0;
  localparam logic [2:0] KIND_DROP      = 3'd1;
  localparam logic [2:0] KIND_FORWARD   = 3'd2;
  localparam logic [2:0] KIND_ROUTE_ERR = 3'd3;
  localparam logic [2:0] KIND_IDLE      = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_ROUTE_PORTS   = 2'd0;
  localparam logic [1:0] REG_DEST_ACTIVE   = 2'd1;
  localparam logic [1:0] REG_BUFFER_LIMITS = 2'd2;

  localparam logic [15:0] BUFFER_LIMITS_RST = 16'h8888;

  typedef struct packed {
    logic [31:0] route_ports;
    logic [15:0] dest_active;
    logic [15:0] buffer_limits;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  port;
    logic [3:0]  destination;
    logic        forced;
    logic        update_flag;
    logic        delete_flag;
    logic [1:0]  forced_port;
    logic [63:0] payload;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  in_port;
    logic [1:0]  egress_port;
    logic [3:0]  out_destination;
    logic        out_forced;
    logic [1:0]  out_forced_port;
    logic [63:0] out_payload;
    logic [3:0]  free_slots;
    logic [31:0] counter_value;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic tick_start;
    logic arr_do;
    logic rd_issue;
    logic eval_do;
    logic next_port;
    logic final_do;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_mode;
    logic head_empty;
    logic last_port;
    logic pend_valid;
    logic eval_emits;
    logic out_free;
  } status_t;

endpackage

// File: src/nir_if.sv
// Request and result channel interfaces of the router.
interface nir_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [1:0]  port;
  logic [3:0]  destination;
  logic        forced;
  logic        update_flag;
  logic        delete_flag;
  logic [1:0]  forced_port;
  logic [63:0] payload;

  modport source(output valid, mode, port, destination, forced, update_flag, delete_flag,
                 forced_port, payload, input ready);
  modport sink(input valid, mode, port, destination, forced, update_flag, delete_flag,
               forced_port, payload, output ready);
endinterface

interface nir_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  in_port;
  logic [1:0]  egress_port;
  logic [3:0]  out_destination;
  logic        out_forced;
  logic [1:0]  out_forced_port;
  logic [63:0] out_payload;
  logic [3:0]  free_slots;
  logic [31:0] counter_value;
  logic        last;

  modport source(output valid, kind, in_port, egress_port, out_destination, out_forced,
                 out_forced_port, out_payload, free_slots, counter_value, last,
                 input ready);
  modport sink(input valid, kind, in_port, egress_port, out_destination, out_forced,
               out_forced_port, out_payload, free_slots, counter_value, last,
               output ready);
endinterface

// File: src/nir_cfg.sv
// Configuration registers behind the APB-style port.
module nir_cfg (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output nir_pkg::cfg_t       cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; an address past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.route_ports   <= '0;
      cfg.dest_active   <= '0;
      cfg.buffer_limits <= nir_pkg::BUFFER_LIMITS_RST;
    end else if (wr_en) begin
      case (reg_idx)
        nir_pkg::REG_ROUTE_PORTS:   cfg.route_ports   <= pwdata;
        nir_pkg::REG_DEST_ACTIVE:   cfg.dest_active   <= pwdata[15:0];
        nir_pkg::REG_BUFFER_LIMITS: cfg.buffer_limits <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (reg_idx)
      nir_pkg::REG_ROUTE_PORTS:   prdata = cfg.route_ports;
      nir_pkg::REG_DEST_ACTIVE:   prdata = {16'h0, cfg.dest_active};
      nir_pkg::REG_BUFFER_LIMITS: prdata = {16'h0, cfg.buffer_limits};
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: src/nir_ctrl.sv
// Controller state machine that sequences arrivals and the tick scan.
module nir_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nir_pkg::status_t   st,
  output nir_pkg::cmd_t      cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_ARRIVE   = 6'b000100,
    S_CHECK    = 6'b001000,
    S_EVAL     = 6'b010000,
    S_FINAL    = 6'b100000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.in_mode) begin
          cmd.tick_start = 1'b1;
          state_next     = S_CHECK;
        end else begin
          state_next = S_ARRIVE;
        end
      end
      S_ARRIVE: begin
        if (st.out_free) begin
          cmd.arr_do = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        if (st.head_empty) begin
          cmd.next_port = 1'b1;
          state_next    = st.last_port ? S_FINAL : S_CHECK;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_EVAL;
        end
      end
      S_EVAL: begin
        // A new result pushes the held one out, so the output must be free.
        if (!(st.eval_emits && st.pend_valid && !st.out_free)) begin
          cmd.eval_do   = 1'b1;
          cmd.next_port = 1'b1;
          state_next    = st.last_port ? S_FINAL : S_CHECK;
        end
      end
      S_FINAL: begin
        if (st.out_free) begin
          cmd.final_do = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/nir_dp.sv
// Datapath: port queues, counters, routing logic and the result register.
module nir_dp #(
  parameter int NUM_PORTS   = nir_pkg::NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH = nir_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_DESTS   = nir_pkg::NUM_DESTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  nir_pkg::item_t     in_item,
  input  nir_pkg::cfg_t      cfg,
  input  nir_pkg::cmd_t      cmd,
  output nir_pkg::status_t   st,
  output logic               out_valid,
  input  logic               out_ready,
  output nir_pkg::result_t   out_res
);

  localparam int PW    = $clog2(NUM_PORTS);
  localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOTS = NUM_PORTS * QUEUE_DEPTH;
  localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW    = 73;

  nir_pkg::item_t   in_r;
  logic [HW-1:0]    head [NUM_PORTS];
  logic [CW-1:0]    count [NUM_PORTS];
  logic [31:0]      rcv_cnt [NUM_PORTS];
  logic [31:0]      snt_cnt [NUM_PORTS];
  logic [31:0]      drp_cnt [NUM_PORTS];
  logic [EW-1:0]    mem [SLOTS];
  logic [EW-1:0]    rd_data;
  logic [PW-1:0]    idx;
  logic [3:0]       used;
  nir_pkg::result_t pend;
  nir_pkg::result_t fin_res;
  logic             pend_valid;
  logic             out_free;

  // Limit of a port, clamped to the queue depth.
  function automatic logic [CW-1:0] lim_of(logic [PW-1:0] p, logic [15:0] bl);
    logic [3:0] nib;
    nib = 4'(QUEUE_DEPTH);
    for (int k = 0; k < 4; k++) begin
      if (32'(p) == k) begin
        nib = (bl[4*k +: 4] > 4'(QUEUE_DEPTH)) ? 4'(QUEUE_DEPTH) : bl[4*k +: 4];
      end
    end
    return CW'(nib);
  endfunction

  function automatic logic [3:0] free_of(logic [CW-1:0] c, logic [CW-1:0] lim);
    return (c >= lim) ? 4'd0 : 4'(lim - c);
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == nir_pkg::SAT32) ? v : v + 32'd1;
  endfunction

  // Arrival side.
  logic [PW-1:0]    ap;
  logic             ap_ok;
  logic [CW-1:0]    a_lim;
  logic [CW-1:0]    a_cnt;
  logic             a_full;
  logic             a_push;
  logic [4:0]       a_off;
  logic [AW-1:0]    a_slot;
  logic [31:0]      a_rcv;
  logic [31:0]      a_drp;
  nir_pkg::result_t a_res;

  assign ap     = PW'(in_r.port);
  assign ap_ok  = 32'(in_r.port) < NUM_PORTS;
  assign a_lim  = lim_of(ap, cfg.buffer_limits);
  assign a_cnt  = count[ap];
  assign a_full = a_cnt >= a_lim;
  assign a_push = cmd.arr_do && ap_ok && !a_full;
  assign a_rcv  = sat_inc(rcv_cnt[ap]);
  assign a_drp  = sat_inc(drp_cnt[ap]);

  // Tail position, wrapped with one compare and subtract.
  always_comb begin
    a_off = 5'(head[ap]) + 5'(a_cnt);
    if (a_off >= 5'(QUEUE_DEPTH)) begin
      a_off = a_off - 5'(QUEUE_DEPTH);
    end
    a_slot = AW'(32'(ap) * QUEUE_DEPTH) + AW'(a_off);
  end

  always_comb begin
    a_res         = '0;
    a_res.in_port = in_r.port;
    a_res.last    = 1'b1;
    if (!ap_ok) begin
      a_res.kind = nir_pkg::KIND_DROP;
    end else if (!a_full) begin
      a_res.kind          = nir_pkg::KIND_ACCEPT;
      a_res.free_slots    = free_of(a_cnt + CW'(1), a_lim);
      a_res.counter_value = a_rcv;
    end else begin
      a_res.kind          = nir_pkg::KIND_DROP;
      a_res.free_slots    = free_of(a_cnt, a_lim);
      a_res.counter_value = a_drp;
    end
  end

  // Head evaluation during a tick.
  logic [AW-1:0]    rd_slot;
  logic [8:0]       hdr;
  logic [3:0]       dst;
  logic             f_bit;
  logic             u_bit;
  logic             d_bit;
  logic [1:0]       op;
  logic             route_ok;
  logic             emits;
  logic [CW-1:0]    e_cnt;
  logic [CW-1:0]    e_lim;
  logic [HW-1:0]    e_head;
  logic [31:0]      e_snt;
  logic [31:0]      e_drp;
  nir_pkg::result_t e_res;

  assign rd_slot = AW'(32'(idx) * QUEUE_DEPTH) + AW'(head[idx]);
  assign hdr     = rd_data[72:64];
  assign dst     = hdr[3:0];
  assign f_bit   = hdr[4];
  assign u_bit   = hdr[5];
  assign d_bit   = hdr[6];
  assign e_cnt   = count[idx] - CW'(1);
  assign e_lim   = lim_of(idx, cfg.buffer_limits);
  assign e_head  = (32'(head[idx]) == QUEUE_DEPTH - 1) ? '0 : head[idx] + HW'(1);
  assign e_snt   = sat_inc(snt_cnt[idx]);
  assign e_drp   = sat_inc(drp_cnt[idx]);

  always_comb begin
    op       = 2'd0;
    route_ok = 1'b0;
    if (f_bit && !u_bit && !d_bit) begin
      op       = hdr[8:7];
      route_ok = 1'b1;
    end else if ((!f_bit && u_bit && !d_bit) || (!f_bit && !u_bit && d_bit)) begin
      route_ok = 1'b0;
    end else if (32'(dst) < NUM_DESTS && cfg.dest_active[dst]) begin
      op       = cfg.route_ports[{dst, 1'b0} +: 2];
      route_ok = 1'b1;
    end
    if (route_ok && 32'(op) >= NUM_PORTS) begin
      route_ok = 1'b0;
    end
  end

  assign emits = !route_ok || !used[op];

  always_comb begin
    e_res            = '0;
    e_res.in_port    = 2'(idx);
    e_res.free_slots = free_of(e_cnt, e_lim);
    if (!route_ok) begin
      e_res.kind          = nir_pkg::KIND_ROUTE_ERR;
      e_res.counter_value = e_drp;
    end else begin
      e_res.kind            = nir_pkg::KIND_FORWARD;
      e_res.egress_port     = op;
      e_res.out_destination = dst;
      e_res.out_forced      = f_bit;
      e_res.out_forced_port = hdr[8:7];
      e_res.out_payload     = rd_data[63:0];
      e_res.counter_value   = e_snt;
    end
  end

  // Packet store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (a_push) begin
      mem[a_slot] <= {in_r.forced_port, in_r.delete_flag, in_r.update_flag, in_r.forced,
                      in_r.destination, in_r.payload};
    end
    if (cmd.rd_issue) begin
      rd_data <= mem[rd_slot];
    end
  end

  // Latched request.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_item;
    end
  end

  // Queue pointers and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PORTS; i++) begin
        head[i]    <= '0;
        count[i]   <= '0;
        rcv_cnt[i] <= '0;
        snt_cnt[i] <= '0;
        drp_cnt[i] <= '0;
      end
    end else if (cmd.arr_do && ap_ok) begin
      rcv_cnt[ap] <= a_rcv;
      if (a_full) begin
        drp_cnt[ap] <= a_drp;
      end else begin
        count[ap] <= a_cnt + CW'(1);
      end
    end else if (cmd.eval_do && emits) begin
      head[idx]  <= e_head;
      count[idx] <= e_cnt;
      if (route_ok) begin
        snt_cnt[idx] <= e_snt;
      end else begin
        drp_cnt[idx] <= e_drp;
      end
    end
  end

  // Scan index and output ports taken during this tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      used <= '0;
    end else if (cmd.tick_start) begin
      idx  <= '0;
      used <= '0;
    end else begin
      if (cmd.eval_do && emits && route_ok) begin
        used[op] <= 1'b1;
      end
      if (cmd.next_port) begin
        idx <= idx + PW'(1);
      end
    end
  end

  // Closing result of a tick: the held result marked last, or an idle result.
  always_comb begin
    if (pend_valid) begin
      fin_res = pend;
    end else begin
      fin_res      = '0;
      fin_res.kind = nir_pkg::KIND_IDLE;
    end
    fin_res.last = 1'b1;
  end

  // Output register.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.arr_do) begin
      out_valid <= 1'b1;
      out_res   <= a_res;
    end else if (cmd.eval_do && emits && pend_valid) begin
      out_valid <= 1'b1;
      out_res   <= pend;
    end else if (cmd.final_do) begin
      out_valid <= 1'b1;
      out_res   <= fin_res;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Held result of the tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.tick_start || cmd.final_do) begin
      pend_valid <= 1'b0;
    end else if (cmd.eval_do && emits) begin
      pend       <= e_res;
      pend_valid <= 1'b1;
    end
  end

  assign st.in_mode    = in_r.mode;
  assign st.head_empty = (count[idx] == '0);
  assign st.last_port  = (idx == PW'(NUM_PORTS - 1));
  assign st.pend_valid = pend_valid;
  assign st.eval_emits = emits;
  assign st.out_free   = out_free;

endmodule

// File: src/noc_input_queued_router.sv
// Top level of the input-queued router: channels, configuration port and core.
// An arrival request passes through the DISPATCH and ARRIVE states and then places its
// result in the output register. A tick checks the input queues in turn and reads the
// non-empty heads one at a time through the single read port of the shared packet
// memory; each head is routed from the registered read data in the EVAL state that
// follows its read. A new request is taken once the previous one has placed its last
// result in the output register, even while that result waits. Output stalls hold
// the controller in the ARRIVE, EVAL or FINAL state. Queue memory needs no clearing
// after reset.
module noc_input_queued_router #(
  parameter int NUM_PORTS   = nir_pkg::NUM_PORTS_DEF,
  parameter int QUEUE_DEPTH = nir_pkg::QUEUE_DEPTH_DEF,
  parameter int NUM_DESTS   = nir_pkg::NUM_DESTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  nir_in_if.sink      in_ch,
  nir_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  nir_pkg::cfg_t    cfg;
  nir_pkg::cmd_t    cmd;
  nir_pkg::status_t st;
  nir_pkg::item_t   in_item;
  nir_pkg::result_t res;

  // Pack the request fields.
  assign in_item.mode        = in_ch.mode;
  assign in_item.port        = in_ch.port;
  assign in_item.destination = in_ch.destination;
  assign in_item.forced      = in_ch.forced;
  assign in_item.update_flag = in_ch.update_flag;
  assign in_item.delete_flag = in_ch.delete_flag;
  assign in_item.forced_port = in_ch.forced_port;
  assign in_item.payload     = in_ch.payload;

  nir_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  nir_dp #(
    .NUM_PORTS   (NUM_PORTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_DESTS   (NUM_DESTS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cfg       (cfg),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  // Unpack the result register onto the channel.
  assign out_ch.kind            = res.kind;
  assign out_ch.in_port         = res.in_port;
  assign out_ch.egress_port     = res.egress_port;
  assign out_ch.out_destination = res.out_destination;
  assign out_ch.out_forced      = res.out_forced;
  assign out_ch.out_forced_port = res.out_forced_port;
  assign out_ch.out_payload     = res.out_payload;
  assign out_ch.free_slots      = res.free_slots;
  assign out_ch.counter_value   = res.counter_value;
  assign out_ch.last            = res.last;

endmodule

// File: src/nir_checker.sv
// Port-level checks of the router and their binding to the top level.
module nir_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [1:0]  egress_port,
  input logic [63:0] out_payload,
  input logic        out_last
);

  // A stalled result keeps its kind and payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_payload))
    else $error("result changed while stalled");

  // No result is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // An arrival gives exactly one result, so it always closes its request.
  a_arr_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind == nir_pkg::KIND_ACCEPT || out_kind == nir_pkg::KIND_DROP)
    |-> out_last)
    else $error("arrival result without last");

  // A quiet tick result is alone and last.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == nir_pkg::KIND_IDLE |-> out_last && out_payload == 64'd0)
    else $error("idle result malformed");

  // Only forwarded results carry packet fields.
  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != nir_pkg::KIND_FORWARD |-> out_payload == 64'd0 &&
    egress_port == 2'd0)
    else $error("packet fields on a non-forwarded result");

endmodule

bind noc_input_queued_router nir_checker u_nir_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_kind    (out_ch.kind),
  .egress_port (out_ch.egress_port),
  .out_payload (out_ch.out_payload),
  .out_last    (out_ch.last)
);

// File: sim/tb_noc_input_queued_router.sv
// Testbench of the input-queued router: directed and random request traffic checked against a router model.
module tb_noc_input_queued_router;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPORT = 4;
  localparam int DEPTH = 8;
  localparam int LIMIT_CYCLES = 400000;

  // Router model: queues, counters and the expected result store.
  class router_scoreboard;
    logic [31:0] route_tbl;
    logic [15:0] active_mask;
    logic [15:0] limits;
    logic [8:0]  hdr_mem [NPORT][DEPTH];
    logic [63:0] pay_mem [NPORT][DEPTH];
    int unsigned head [NPORT];
    int unsigned fill [NPORT];
    logic [31:0] rcv_cnt [NPORT];
    logic [31:0] snt_cnt [NPORT];
    logic [31:0] drp_cnt [NPORT];
    nir_pkg::result_t pending [$];
    int errors;
    int checked;

    function void clear();
      route_tbl = '0;
      active_mask = '0;
      limits = nir_pkg::BUFFER_LIMITS_RST;
      pending.delete();
      for (int p = 0; p < NPORT; p++) begin
        head[p] = 0;
        fill[p] = 0;
        rcv_cnt[p] = '0;
        snt_cnt[p] = '0;
        drp_cnt[p] = '0;
      end
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      if (idx == nir_pkg::REG_ROUTE_PORTS) route_tbl = val;
      else if (idx == nir_pkg::REG_DEST_ACTIVE) active_mask = val[15:0];
      else if (idx == nir_pkg::REG_BUFFER_LIMITS) limits = val[15:0];
    endfunction

    function int unsigned limit_of(int p);
      int unsigned lim;
      lim = (limits >> (4 * p)) & 4'hF;
      return lim > DEPTH ? DEPTH : lim;
    endfunction

    function logic [3:0] free_of(int p);
      int unsigned lim;
      lim = limit_of(p);
      return fill[p] >= lim ? 4'd0 : 4'(lim - fill[p]);
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return v == nir_pkg::SAT32 ? v : v + 1;
    endfunction

    function void push_result(logic [2:0] k, int p, logic [3:0] fs, logic [31:0] cnt);
      nir_pkg::result_t r;
      r = '0;
      r.kind = k;
      r.in_port = p[1:0];
      r.free_slots = fs;
      r.counter_value = cnt;
      pending.insert(pending.size(), r);
    endfunction

    // Note an accepted request and queue the results it causes.
    function void note_request(nir_pkg::item_t it);
      int p;
      int n;
      logic used [NPORT];
      logic [8:0] h;
      logic ok;
      logic [1:0] op;
      nir_pkg::result_t r;
      n = 0;
      if (!it.mode) begin
        p = it.port;
        rcv_cnt[p] = bump(rcv_cnt[p]);
        if (fill[p] < limit_of(p)) begin
          hdr_mem[p][(head[p] + fill[p]) % DEPTH] =
            {it.forced_port, it.delete_flag, it.update_flag, it.forced, it.destination};
          pay_mem[p][(head[p] + fill[p]) % DEPTH] = it.payload;
          fill[p]++;
          push_result(nir_pkg::KIND_ACCEPT, p, free_of(p), rcv_cnt[p]);
        end else begin
          drp_cnt[p] = bump(drp_cnt[p]);
          push_result(nir_pkg::KIND_DROP, p, free_of(p), drp_cnt[p]);
        end
        pending[$].last = 1'b1;
        return;
      end
      for (int i = 0; i < NPORT; i++) used[i] = 1'b0;
      for (int i = 0; i < NPORT; i++) begin
        if (fill[i] == 0) continue;
        h = hdr_mem[i][head[i]];
        ok = 1'b0;
        op = '0;
        if (h[4] && !h[5] && !h[6]) begin
          op = h[8:7];
          ok = 1'b1;
        end else if (!h[4] && (h[5] ^ h[6])) begin
          ok = 1'b0;
        end else if (active_mask[h[3:0]]) begin
          op = route_tbl[2 * h[3:0] +: 2];
          ok = 1'b1;
        end
        if (!ok) begin
          head[i] = (head[i] + 1) % DEPTH;
          fill[i]--;
          drp_cnt[i] = bump(drp_cnt[i]);
          push_result(nir_pkg::KIND_ROUTE_ERR, i, free_of(i), drp_cnt[i]);
          n++;
        end else if (!used[op]) begin
          used[op] = 1'b1;
          r = '0;
          r.kind = nir_pkg::KIND_FORWARD;
          r.in_port = i[1:0];
          r.egress_port = op;
          r.out_destination = h[3:0];
          r.out_forced = h[4];
          r.out_forced_port = h[8:7];
          r.out_payload = pay_mem[i][head[i]];
          head[i] = (head[i] + 1) % DEPTH;
          fill[i]--;
          snt_cnt[i] = bump(snt_cnt[i]);
          r.free_slots = free_of(i);
          r.counter_value = snt_cnt[i];
          pending.insert(pending.size(), r);
          n++;
        end
      end
      if (n == 0) push_result(nir_pkg::KIND_IDLE, 0, 4'd0, 32'd0);
      pending[$].last = 1'b1;
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(nir_pkg::result_t got);
      nir_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.kind !== exp_r.kind || got.in_port !== exp_r.in_port ||
          got.egress_port !== exp_r.egress_port ||
          got.out_destination !== exp_r.out_destination ||
          got.out_forced !== exp_r.out_forced || got.out_forced_port !== exp_r.out_forced_port ||
          got.out_payload !== exp_r.out_payload || got.free_slots !== exp_r.free_slots ||
          got.counter_value !== exp_r.counter_value || got.last !== exp_r.last) begin
        $display("%0t: result mismatch, expected %h, actual %h", $realtime, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  int cycle_cnt;
  int n_requests;
  int n_ticks;
  logic stall_hold;

  nir_in_if in_ch();
  nir_out_if out_ch();
  router_scoreboard sb;

  noc_input_queued_router u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle limit guards against a hang.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("FAIL noc_input_queued_router");
      $finish;
    end
  end

  // Results are checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result({out_ch.kind, out_ch.in_port, out_ch.egress_port,
                       out_ch.out_destination, out_ch.out_forced, out_ch.out_forced_port,
                       out_ch.out_payload, out_ch.free_slots, out_ch.counter_value,
                       out_ch.last});
    end
  end

  // Receiver stalls: long quiet stretches alternate with heavy stalling.
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b1;
    end else if (stall_hold) begin
      out_ch.ready <= ($urandom_range(0, 99) < 40);
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 95);
    end
  end

  always @(negedge clk) begin
    if (rst) stall_hold <= 1'b0;
    else if ($urandom_range(0, 63) == 0) stall_hold <= ~stall_hold;
  end

  // Register write over the configuration port, setup then access.
  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Send one request and record it once accepted.
  task automatic send_request(nir_pkg::item_t it);
    in_ch.valid <= 1'b1;
    {in_ch.mode, in_ch.port, in_ch.destination, in_ch.forced, in_ch.update_flag,
     in_ch.delete_flag, in_ch.forced_port, in_ch.payload} <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(it);
    n_requests++;
    if (it.mode) n_ticks++;
    @(negedge clk);
  endtask

  task automatic idle_input();
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every expected result is back and the block is quiet.
  task automatic drain();
    idle_input();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  function automatic nir_pkg::item_t make_arrival(int p, logic [3:0] d, logic f, logic u,
                                                  logic x, logic [1:0] fp,
                                                  logic [63:0] pay);
    nir_pkg::item_t it;
    it = '0;
    it.port = p[1:0];
    it.destination = d;
    it.forced = f;
    it.update_flag = u;
    it.delete_flag = x;
    it.forced_port = fp;
    it.payload = pay;
    return it;
  endfunction

  function automatic nir_pkg::item_t make_tick();
    nir_pkg::item_t it;
    it = '0;
    it.mode = 1'b1;
    it.payload = {$urandom, $urandom};
    it.port = $urandom_range(0, 3);
    return it;
  endfunction

  // Random arrival: mostly routable, some route updates, deletions and noise.
  function automatic nir_pkg::item_t rand_arrival();
    int sel;
    logic f, u, x;
    sel = $urandom_range(0, 99);
    f = 1'b0;
    u = 1'b0;
    x = 1'b0;
    if (sel < 35) f = 1'b1;
    else if (sel < 45) u = 1'b1;
    else if (sel < 55) x = 1'b1;
    else if (sel < 65) {f, u, x} = 3'($urandom_range(3, 7));
    return make_arrival($urandom_range(0, 3), 4'($urandom_range(0, 15)), f, u, x,
                        2'($urandom_range(0, 3)), {$urandom, $urandom});
  endfunction

  // One phase of random traffic in bursts with gaps.
  task automatic random_phase(int count, int tick_pct);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(0, 99) < tick_pct) send_request(make_tick());
        else send_request(rand_arrival());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_input();
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    sb.errors = 0;
    sb.checked = 0;
    cycle_cnt = 0;
    n_requests = 0;
    n_ticks = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    {in_ch.mode, in_ch.port, in_ch.destination, in_ch.forced, in_ch.update_flag,
     in_ch.delete_flag, in_ch.forced_port, in_ch.payload} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: quiet tick, inactive route, forced routes, fill to drop.
    send_request(make_tick());
    send_request(make_arrival(0, 4'd3, 1'b0, 1'b0, 1'b0, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_request(make_tick());
    drain();
    reg_write(nir_pkg::REG_ROUTE_PORTS, 32'hE4E4_E4E4);
    reg_write(nir_pkg::REG_DEST_ACTIVE, 16'hFFFF);
    reg_write(nir_pkg::REG_BUFFER_LIMITS, 16'h0F21);
    send_request(make_arrival(0, 4'd15, 1'b1, 1'b0, 1'b0, 2'd3, 64'h0));
    send_request(make_arrival(0, 4'd0, 1'b1, 1'b0, 1'b0, 2'd3, 64'h1234));
    send_request(make_arrival(1, 4'd1, 1'b0, 1'b0, 1'b0, 2'd0, 64'h5555_AAAA_5555_AAAA));
    send_request(make_arrival(1, 4'd2, 1'b0, 1'b1, 1'b0, 2'd0, 64'hAAAA_5555_AAAA_5555));
    send_request(make_arrival(2, 4'd7, 1'b0, 1'b1, 1'b0, 2'd1, 64'h1));
    send_request(make_arrival(2, 4'd6, 1'b0, 1'b0, 1'b1, 2'd2, 64'h2));
    send_request(make_arrival(3, 4'd3, 1'b1, 1'b1, 1'b1, 2'd3, 64'h3));
    send_request(make_arrival(3, 4'd15, 1'b1, 1'b0, 1'b0, 2'd3, 64'h4));
    send_request(make_tick());
    send_request(make_tick());
    send_request(make_tick());
    send_request(make_tick());
    drain();

    // Random phases across several table and limit settings.
    reg_write(nir_pkg::REG_BUFFER_LIMITS, 16'h8888);
    reg_write(nir_pkg::REG_DEST_ACTIVE, 16'h5A5A);
    reg_write(nir_pkg::REG_ROUTE_PORTS, $urandom);
    random_phase(120, 35);
    drain();
    reg_write(nir_pkg::REG_BUFFER_LIMITS, 16'hFFFF);
    reg_write(nir_pkg::REG_DEST_ACTIVE, 16'hFFFF);
    reg_write(nir_pkg::REG_ROUTE_PORTS, 32'h0);
    random_phase(120, 30);
    drain();
    reg_write(nir_pkg::REG_BUFFER_LIMITS, 16'h0000);
    reg_write(nir_pkg::REG_DEST_ACTIVE, 16'h0000);
    random_phase(20, 40);
    drain();
    reg_write(nir_pkg::REG_BUFFER_LIMITS, 16'($urandom));
    reg_write(nir_pkg::REG_DEST_ACTIVE, 16'($urandom));
    reg_write(nir_pkg::REG_ROUTE_PORTS, 32'hFFFF_FFFF);
    random_phase(100, 40);
    drain();
    reg_write(nir_pkg::REG_BUFFER_LIMITS, 16'h3548);
    reg_write(nir_pkg::REG_ROUTE_PORTS, $urandom);
    random_phase(80, 30);
    for (int k = 0; k < 10; k++) send_request(make_tick());
    drain();

    $display("Run covered %0d requests (%0d ticks) and %0d checked results,",
             n_requests, n_ticks, sb.checked);
    $display("with forced, table, error, drop and idle-tick cases over six settings.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS noc_input_queued_router");
    end else begin
      $display("FAIL noc_input_queued_router");
    end
    $finish;
  end
endmodule
